@@ rtl/hmf_pkg.sv @@
// Shared types and constants for the histogram mode finder.
// Used by hmf_mode_track and histogram_mode_finder; no dependencies of its own.
`timescale 1ns / 1ps
`default_nettype none

package hmf_pkg;

	// Width of the set tag kept with every histogram entry. Tag zero marks a cleared entry.
	localparam int EPOCH_BITS = 8;

	typedef logic [EPOCH_BITS-1:0] epoch_t;

	localparam epoch_t EPOCH_FIRST = epoch_t'(1);
	localparam epoch_t EPOCH_MAX   = {EPOCH_BITS{1'b1}};
	localparam epoch_t EPOCH_CLEAR = epoch_t'(0);

	typedef enum logic [1:0] {
		ST_SWEEP = 2'b01,
		ST_RUN   = 2'b10
	} hmf_state_t;

	// Control of the update stage for one cycle.
	typedef struct packed {
		logic upd;   // the stage item advances this cycle
		logic elem;  // the item carries an element
		logic last;  // the item closes the set
	} hmf_step_t;

endpackage

`default_nettype wire

@@ rtl/hmf_count_ram.sv @@
// Histogram store: one synchronous single-port-write, registered-read memory.
// Generic; uses no package items.
`timescale 1ns / 1ps
`default_nettype none

module hmf_count_ram #(
	parameter int ADDR_BITS = 8,
	parameter int DATA_BITS = 24
) (
	input  logic                 clk,
	input  logic                 rd_en,
	input  logic [ADDR_BITS-1:0] rd_addr,
	output logic [DATA_BITS-1:0] rd_data,
	input  logic                 wr_en,
	input  logic [ADDR_BITS-1:0] wr_addr,
	input  logic [DATA_BITS-1:0] wr_data
);

	logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read-first: a read at the address being written returns the old entry.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/hmf_mode_track.sv @@
// Running best value and best count of the current set.
// Depends on hmf_pkg for the step control struct.
`timescale 1ns / 1ps
`default_nettype none

module hmf_mode_track #(
	parameter int VALUE_BITS = 8,
	parameter int COUNT_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  hmf_pkg::hmf_step_t           step,
	input  logic signed [VALUE_BITS-1:0] value,
	input  logic        [COUNT_BITS-1:0] count,
	output logic signed [VALUE_BITS-1:0] res_value,
	output logic        [COUNT_BITS-1:0] res_count
);

	import hmf_pkg::*;

	logic signed [VALUE_BITS-1:0] best_value_q;
	logic        [COUNT_BITS-1:0] best_count_q;
	logic                         better;

	// Strict greater count, or an equal count with a smaller value, reproduces
	// an ascending scan that keeps the first maximum.
	assign better = step.elem &&
		((count > best_count_q) || ((count == best_count_q) && (value < best_value_q)));

	assign res_value = better ? value : best_value_q;
	assign res_count = better ? count : best_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_value_q <= '0;
			best_count_q <= '0;
		end else if (step.upd) begin
			if (step.last) begin
				best_value_q <= '0;
				best_count_q <= '0;
			end else begin
				best_value_q <= res_value;
				best_count_q <= res_count;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/histogram_mode_finder.sv @@
// Top level of the histogram mode finder: input stage, read-modify-write of the
// histogram with forwarding, tag clearing pass and result register.
// Depends on hmf_pkg, hmf_count_ram and hmf_mode_track.
//
// Usage:
// The element channel (elem_valid / elem_ready) takes one transaction per cycle while
// elem_ready is high, each carrying element_value, no_element and last. A transaction
// with last set closes the set; the mode channel (mode_valid / mode_ready) then
// presents one transaction with the most frequent value (smallest on ties) and its
// saturating count, or 0,0 for an empty set.
// The closing transaction passes the input stage and then sets mode_valid in the result
// register. Throughput: one element per cycle while elem_ready is high. The histogram
// memory is read when an element is accepted and written back as it leaves the input
// stage; a repeat of the same value next takes its count from a forwarding register.
// Every entry carries a set tag. After reset, and after every 255th set, a
// clearing pass writes all 2^VALUE_BITS entries, one per cycle, with elem_ready low;
// after a set, its closing transaction in the input stage holds off input as well.
// When the receiver stalls, the result is held in the output register and
// elements keep flowing; only a closing transaction waits for the register to free.
`timescale 1ns / 1ps
`default_nettype none

module histogram_mode_finder #(
	parameter int VALUE_BITS = 8,
	parameter int COUNT_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         elem_valid,
	output logic                         elem_ready,
	input  logic signed [VALUE_BITS-1:0] element_value,
	input  logic                         no_element,
	input  logic                         last,
	output logic                         mode_valid,
	input  logic                         mode_ready,
	output logic signed [VALUE_BITS-1:0] mode_value,
	output logic        [COUNT_BITS-1:0] mode_count
);

	import hmf_pkg::*;

	localparam int DATA_BITS = EPOCH_BITS + COUNT_BITS;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [VALUE_BITS-1:0] ADDR_LAST = {VALUE_BITS{1'b1}};

	hmf_state_t state_q;
	logic [VALUE_BITS-1:0] sweep_addr_q;
	epoch_t epoch_q;

	logic                         valid_s1;
	logic signed [VALUE_BITS-1:0] value_s1;
	logic                         elem_s1;
	logic                         last_s1;

	logic                  fwd_valid_q;
	logic [VALUE_BITS-1:0] fwd_addr_q;
	logic [COUNT_BITS-1:0] fwd_count_q;

	logic                         mode_valid_q;
	logic signed [VALUE_BITS-1:0] mode_value_q;
	logic        [COUNT_BITS-1:0] mode_count_q;

	logic                  accept;
	logic                  adv;
	logic                  sweeping;
	logic [DATA_BITS-1:0]  rd_data;
	epoch_t                rd_tag;
	logic [COUNT_BITS-1:0] rd_count;
	logic [COUNT_BITS-1:0] base_count;
	logic [COUNT_BITS-1:0] new_count;
	logic                  wr_en;
	logic [VALUE_BITS-1:0] wr_addr;
	logic [DATA_BITS-1:0]  wr_data;
	hmf_step_t             step;
	logic signed [VALUE_BITS-1:0] res_value;
	logic        [COUNT_BITS-1:0] res_count;

	assign sweeping = (state_q == ST_SWEEP);
	assign accept   = elem_valid && elem_ready;

	// A closing item waits only when the result register is full and not being taken.
	assign adv = valid_s1 && (!last_s1 || !mode_valid_q || mode_ready);

	// The item that closes the last set before a clearing pass holds off new input.
	assign elem_ready = !sweeping &&
		(!valid_s1 || (adv && !(last_s1 && (epoch_q == EPOCH_MAX))));

	assign {rd_tag, rd_count} = rd_data;

	always_comb begin
		if (fwd_valid_q && (fwd_addr_q == value_s1)) begin
			base_count = fwd_count_q;
		end else if (rd_tag == epoch_q) begin
			base_count = rd_count;
		end else begin
			base_count = '0;
		end
		new_count = (base_count == CNT_MAX) ? base_count : base_count + 1'b1;
	end

	always_comb begin
		if (sweeping) begin
			wr_en   = 1'b1;
			wr_addr = sweep_addr_q;
			wr_data = {EPOCH_CLEAR, {COUNT_BITS{1'b0}}};
		end else begin
			wr_en   = adv && elem_s1;
			wr_addr = value_s1;
			wr_data = {epoch_q, new_count};
		end
	end

	hmf_count_ram #(
		.ADDR_BITS(VALUE_BITS),
		.DATA_BITS(DATA_BITS)
	) u_ram (
		.clk    (clk),
		.rd_en  (accept),
		.rd_addr(element_value),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	assign step = '{upd: adv, elem: elem_s1, last: last_s1};

	hmf_mode_track #(
		.VALUE_BITS(VALUE_BITS),
		.COUNT_BITS(COUNT_BITS)
	) u_track (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.value    (value_s1),
		.count    (new_count),
		.res_value(res_value),
		.res_count(res_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			sweep_addr_q <= '0;
			epoch_q      <= EPOCH_FIRST;
		end else begin
			case (state_q)
				ST_SWEEP: begin
					sweep_addr_q <= sweep_addr_q + 1'b1;
					if (sweep_addr_q == ADDR_LAST) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (adv && last_s1) begin
						if (epoch_q == EPOCH_MAX) begin
							state_q      <= ST_SWEEP;
							sweep_addr_q <= '0;
							epoch_q      <= EPOCH_FIRST;
						end else begin
							epoch_q <= epoch_q + 1'b1;
						end
					end
				end
				default: begin
					state_q      <= ST_SWEEP;
					sweep_addr_q <= '0;
					epoch_q      <= EPOCH_FIRST;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			fwd_valid_q  <= 1'b0;
			mode_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			// The entry just written is forwarded to the next element of the same set.
			if (adv) begin
				fwd_valid_q <= elem_s1 && !last_s1;
			end
			if (adv && last_s1) begin
				mode_valid_q <= 1'b1;
			end else if (mode_ready) begin
				mode_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_s1 <= element_value;
			elem_s1  <= !no_element;
			last_s1  <= last;
		end
		if (adv) begin
			fwd_addr_q  <= value_s1;
			fwd_count_q <= new_count;
		end
		if (adv && last_s1) begin
			mode_value_q <= res_value;
			mode_count_q <= res_count;
		end
	end

	assign mode_valid = mode_valid_q;
	assign mode_value = mode_value_q;
	assign mode_count = mode_count_q;

endmodule

`default_nettype wire

@@ rtl/hmf_checker.sv @@
// Port-level checks for the histogram mode finder, bound to its top level.
// Depends only on the ports of histogram_mode_finder.
`timescale 1ns / 1ps
`default_nettype none

module hmf_checker #(
	parameter int VALUE_BITS = 8,
	parameter int COUNT_BITS = 16
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         elem_valid,
	input logic                         elem_ready,
	input logic                         last,
	input logic                         mode_valid,
	input logic                         mode_ready,
	input logic signed [VALUE_BITS-1:0] mode_value,
	input logic        [COUNT_BITS-1:0] mode_count
);

	// A stalled result transaction stays offered.
	a_mode_hold: assert property (@(posedge clk) disable iff (!arst_n)
		mode_valid && !mode_ready |=> mode_valid)
		else $error("result transaction dropped while stalled");

	a_mode_stable: assert property (@(posedge clk) disable iff (!arst_n)
		mode_valid && !mode_ready |=> $stable(mode_value) && $stable(mode_count))
		else $error("result payload changed while stalled");

	// A zero count only comes from an empty set, which reports value zero.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		mode_valid && (mode_count == '0) |-> (mode_value == '0))
		else $error("zero count with nonzero value");

	// The histogram clearing pass keeps input closed right after reset.
	a_sweep_after_reset: assert property (@(posedge clk)
		arst_n && !$past(arst_n) |-> !elem_ready)
		else $error("input accepted during clearing pass");

	// A fresh result follows an accepted closing transaction, via the input stage and result register.
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(mode_valid) |-> $past(elem_valid && elem_ready && last, 2))
		else $error("result without a closing transaction");

endmodule

bind histogram_mode_finder hmf_checker #(
	.VALUE_BITS(VALUE_BITS),
	.COUNT_BITS(COUNT_BITS)
) u_hmf_checker (.*);

`default_nettype wire

@@ test/histogram_mode_finder_tb.sv @@
// Self-checking testbench for histogram_mode_finder: directed table, then random sets.
// Depends only on the block's RTL; a local predictor computes the expected modes the table does not give.
`timescale 1ns / 1ps

module histogram_mode_finder_tb;

	localparam int VALUE_BITS   = 8;
	localparam int COUNT_BITS   = 16;
	localparam int HIST_DEPTH   = 1 << VALUE_BITS;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam int RANDOM_ITEMS = 1320;
	localparam int TAIL_ITEMS   = 150;
	localparam int STALL_LIMIT  = 2000;
	localparam int SCRIPT_ROWS  = 21;

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic [COUNT_BITS-1:0] count;
	} mode_pair_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		bit                    none;
		bit                    closes;
		int                    reps;
		bit                    typed;
		logic [VALUE_BITS-1:0] want_value;
		logic [COUNT_BITS-1:0] want_count;
	} stim_row_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         elem_valid = 1'b0;
	logic                         elem_ready;
	logic signed [VALUE_BITS-1:0] element_value = '0;
	logic                         no_element = 1'b0;
	logic                         last = 1'b0;
	logic                         mode_valid;
	logic                         mode_ready = 1'b0;
	logic signed [VALUE_BITS-1:0] mode_value;
	logic        [COUNT_BITS-1:0] mode_count;

	// Predictor state: counts of the open set and the leading value so far.
	logic [COUNT_BITS-1:0] hist_count [HIST_DEPTH];
	logic [VALUE_BITS-1:0] lead_value = '0;
	logic [COUNT_BITS-1:0] lead_count = '0;
	mode_pair_t            pending_modes [$];
	mode_pair_t            oldest_mode;

	int  fail_count    = 0;
	int  modes_checked = 0;
	int  sets_closed   = 0;
	int  random_sent   = 0;
	int  quiet_cycles  = 0;
	int  idle_chance   = 4;
	int  rcv_hold      = 0;
	int  rcv_cycle     = 0;
	bit  rcv_busy      = 1'b1;
	bit  tail_phase    = 1'b0;

	// Rows: value, no element, closes set, repeats, typed result, mode value, mode count.
	stim_row_t script [SCRIPT_ROWS] = '{
		'{8'h00, 1'b1, 1'b1, 1,     1'b1, 8'h00, 16'd0},      // empty set right after reset
		'{8'h7F, 1'b0, 1'b1, 1,     1'b1, 8'h7F, 16'd1},
		'{8'h80, 1'b0, 1'b1, 1,     1'b1, 8'h80, 16'd1},
		'{8'h64, 1'b1, 1'b0, 1,     1'b0, 8'h00, 16'd0},      // no element, not closing
		'{8'hFF, 1'b1, 1'b1, 1,     1'b1, 8'h00, 16'd0},      // empty set, value ignored
		'{8'hFB, 1'b0, 1'b0, 1,     1'b0, 8'h00, 16'd0},
		'{8'h03, 1'b0, 1'b0, 1,     1'b0, 8'h00, 16'd0},
		'{8'hFB, 1'b0, 1'b0, 1,     1'b0, 8'h00, 16'd0},
		'{8'h03, 1'b0, 1'b1, 1,     1'b0, 8'h00, 16'd0},      // tie across signs
		'{8'h09, 1'b0, 1'b0, 1,     1'b0, 8'h00, 16'd0},
		'{8'h09, 1'b1, 1'b0, 1,     1'b0, 8'h00, 16'd0},
		'{8'h09, 1'b0, 1'b0, 1,     1'b0, 8'h00, 16'd0},
		'{8'h09, 1'b0, 1'b1, 1,     1'b1, 8'h09, 16'd3},      // element on the closing item
		'{8'hFF, 1'b0, 1'b0, 1,     1'b0, 8'h00, 16'd0},
		'{8'h00, 1'b0, 1'b0, 1,     1'b0, 8'h00, 16'd0},
		'{8'h01, 1'b0, 1'b0, 1,     1'b0, 8'h00, 16'd0},
		'{8'hAA, 1'b1, 1'b1, 1,     1'b0, 8'h00, 16'd0},      // non-empty set closed without element
		'{8'h7F, 1'b0, 1'b0, 6,     1'b0, 8'h00, 16'd0},
		'{8'h80, 1'b0, 1'b0, 6,     1'b0, 8'h00, 16'd0},
		'{8'h00, 1'b1, 1'b1, 1,     1'b1, 8'h80, 16'd6},      // extremes tied, smaller wins
		'{8'h80, 1'b0, 1'b1, 1,     1'b1, 8'h80, 16'd1}       // the previous set left nothing
	};

	histogram_mode_finder #(
		.VALUE_BITS(VALUE_BITS),
		.COUNT_BITS(COUNT_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.elem_valid(elem_valid),
		.elem_ready(elem_ready),
		.element_value(element_value),
		.no_element(no_element),
		.last(last),
		.mode_valid(mode_valid),
		.mode_ready(mode_ready),
		.mode_value(mode_value),
		.mode_count(mode_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void tally_mode(input logic [VALUE_BITS-1:0] v, input bit none,
			input bit closes, output bit produced, output mode_pair_t res);
		logic [COUNT_BITS-1:0] c;
		produced = 1'b0;
		res = '0;
		if (!none) begin
			c = hist_count[v];
			if (c != COUNT_MAX)
				c = c + 1'b1;
			hist_count[v] = c;
			if (c > lead_count || (c == lead_count && $signed(v) < $signed(lead_value))) begin
				lead_value = v;
				lead_count = c;
			end
		end
		if (closes) begin
			produced = 1'b1;
			res.value = lead_value;
			res.count = lead_count;
			foreach (hist_count[i])
				hist_count[i] = '0;
			lead_value = '0;
			lead_count = '0;
		end
	endfunction

	// After an optional idle gap, presents one item, holds it until the transaction completes, then predicts.
	task automatic offer_item(input logic [VALUE_BITS-1:0] v, input bit none, input bit closes,
			input bit typed = 1'b0, input mode_pair_t typed_mode = '0);
		int         gap;
		bit         produced;
		mode_pair_t res;
		if (!tail_phase && idle_chance != 0 && $urandom_range(1, idle_chance) == 1) begin
			gap = $urandom_range(1, 7);
			elem_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		elem_valid    <= 1'b1;
		element_value <= v;
		no_element    <= none;
		last          <= closes;
		@(posedge clk);
		while (!elem_ready)
			@(posedge clk);
		tally_mode(v, none, closes, produced, res);
		if (produced) begin
			pending_modes.push_back(typed ? typed_mode : res);
			sets_closed++;
		end
	endtask

	function automatic logic [VALUE_BITS-1:0] pick_value(input int pool,
			input logic [VALUE_BITS-1:0] base);
		case (pool)
			0:       return base + VALUE_BITS'($urandom_range(0, 3));
			1:       return base + VALUE_BITS'($urandom_range(0, 15));
			default: return VALUE_BITS'($urandom);
		endcase
	endfunction

	initial begin
		int                    set_len;
		int                    pool;
		bit                    end_on_elem;
		logic [VALUE_BITS-1:0] base;
		foreach (hist_count[i])
			hist_count[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (script[r]) begin
			for (int k = 0; k < script[r].reps; k++)
				offer_item(script[r].value, script[r].none, script[r].closes, script[r].typed,
					'{script[r].want_value, script[r].want_count});
		end

		while (random_sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5, 6: set_len = $urandom_range(0, 4);
				7, 8:                set_len = $urandom_range(5, 8);
				default:             set_len = $urandom_range(9, 16);
			endcase
			pool        = $urandom_range(0, 2);
			base        = VALUE_BITS'($urandom);
			end_on_elem = $urandom_range(0, 1);
			idle_chance = ($urandom_range(0, 3) == 0) ? 0 : 4;
			for (int i = 0; i < set_len; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					offer_item(VALUE_BITS'($urandom), 1'b1, 1'b0);
					random_sent++;
				end
				offer_item(pick_value(pool, base), 1'b0, end_on_elem && i == set_len - 1);
				random_sent++;
			end
			if (set_len == 0 || !end_on_elem) begin
				offer_item(VALUE_BITS'($urandom), 1'b1, 1'b1);
				random_sent++;
			end
			tail_phase = random_sent >= RANDOM_ITEMS - TAIL_ITEMS;
		end
		elem_valid <= 1'b0;

		while (pending_modes.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Closed %0d sets (%0d random elements and closing items), checked %0d modes,",
			sets_closed, random_sent, modes_checked);
		$display("including empty sets, ties, repeated values and the periodic clearing pass.");
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Result side stalls in random bursts; some stretches never stall.
	always @(posedge clk) begin
		rcv_cycle++;
		if (rcv_cycle % 64 == 0)
			rcv_busy = $urandom_range(0, 2) != 0;
		if (rcv_hold > 0) begin
			rcv_hold   <= rcv_hold - 1;
			mode_ready <= 1'b0;
		end else if (!tail_phase && rcv_busy && $urandom_range(0, 3) == 0) begin
			rcv_hold   <= $urandom_range(0, 6);
			mode_ready <= 1'b0;
		end else begin
			mode_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && mode_valid === 1'b1 && mode_ready) begin
			if (pending_modes.size() == 0) begin
				$error("unexpected result transaction: mode_value %0d, mode_count %0d",
					mode_value, mode_count);
				fail_count++;
			end else begin
				oldest_mode = pending_modes.pop_front();
				if (mode_value !== oldest_mode.value) begin
					$error("mode_value: expected %0d, got %0d",
						$signed(oldest_mode.value), mode_value);
					fail_count++;
				end
				if (mode_count !== oldest_mode.count) begin
					$error("mode_count: expected %0d, got %0d", oldest_mode.count, mode_count);
					fail_count++;
				end
				modes_checked++;
			end
		end
	end

	// The clearing pass after reset and every 255th set keeps elem_ready low for a while.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((elem_valid && elem_ready) || (mode_valid === 1'b1 && mode_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Timeout: no transaction for %0d cycles, %0d results outstanding",
					STALL_LIMIT, pending_modes.size());
				$display("Test completed with failures");
				$finish;
			end
		end
	end

endmodule
